FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Action and status codes and the compare flag bundle of the list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

   typedef enum logic [2:0] {
      ACT_APPEND  = 3'd0,
      ACT_INSERT  = 3'd1,
      ACT_DELETE  = 3'd2,
      ACT_SEARCH  = 3'd3,
      ACT_GET     = 3'd4,
      ACT_SET     = 3'd5,
      ACT_MAXMIN  = 3'd6,
      ACT_REVERSE = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_RANGE     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // outcome of the shared compare unit
   typedef struct packed {
      logic match;   // sample == upper
      logic above;   // sample >  upper
      logic below;   // sample <  lower
   } cmp_flags_type;

   localparam logic [6:0] CAP_RESET = 7'd64;

endpackage

FILE: rtl/array_list_engine.sv
// One request at a time: a new request is taken only once the last result
// word is posted. The store has separate read and write ports. A waiting
// result word does not block the next request. Synchronous reset clears
// the count and sets capacity to 64.
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed words in a store with a count; sequenced actions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_list_engine
   import ale_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic signed [31:0] rsp_largest,
   output logic signed [31:0] rsp_smallest,
   output logic [6:0]         rsp_entry_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_INS, S_PUT, S_DEL, S_SRCH, S_GET, S_MM,
      S_RHI, S_WLO, S_WHI, S_POST
   } state_type;

   state_type                    state_ff;
   action_type                   act_ff;
   logic [5:0]                   pos_ff;
   logic signed [DATA_WIDTH-1:0] val_ff;
   logic [CW-1:0]                count_ff;
   logic [6:0]                   cap_ff;
   logic [CW-1:0]                ptr_ff;     // walk pointer; low end for reverse
   logic [AW-1:0]                wa_ff;      // pending write address; high end for reverse
   logic                         pend_ff;
   logic                         cmp_valid_ff;
   logic [AW-1:0]                cmp_idx_ff;
   logic signed [DATA_WIDTH-1:0] tmp_ff;

   status_type                   res_status_ff;
   logic [AW-1:0]                res_found_ff;
   logic signed [DATA_WIDTH-1:0] res_read_ff;
   logic signed [DATA_WIDTH-1:0] res_big_ff;
   logic signed [DATA_WIDTH-1:0] res_small_ff;

   logic                         rsp_valid_ff;
   status_type                   rsp_status_ff;
   logic [5:0]                   rsp_found_ff;
   logic [31:0]                  rsp_read_ff;
   logic [31:0]                  rsp_big_ff;
   logic [31:0]                  rsp_small_ff;
   logic [6:0]                   rsp_count_ff;

   // store
   logic signed [DATA_WIDTH-1:0] mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic signed [DATA_WIDTH-1:0] mem_wd;
   logic                         mem_re;
   logic [AW-1:0]                mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // checks and walk conditions
   logic [CMPW-1:0] count_x, pos_x, depth_x, cap_x, usable, ptr_x;
   logic [CW-1:0]   ptr_inc, ptr_dec;
   logic [AW-1:0]   pos_a, lo_inc, hi_dec;
   logic            full, ins_bad, pos_ok, ins_more, del_more, scan_more, rev_more;

   always_comb begin
      count_x   = CMPW'(count_ff);
      pos_x     = CMPW'(pos_ff);
      depth_x   = CMPW'(DEPTH);
      cap_x     = CMPW'(cap_ff);
      usable    = (cap_x > depth_x) ? depth_x : cap_x;
      ptr_x     = CMPW'(ptr_ff);
      ptr_inc   = ptr_ff + 1'b1;
      ptr_dec   = ptr_ff - 1'b1;
      pos_a     = AW'(pos_ff);
      lo_inc    = ptr_ff[AW-1:0] + 1'b1;
      hi_dec    = wa_ff - 1'b1;
      full      = (count_x >= usable);
      ins_bad   = (pos_x > count_x);
      pos_ok    = (pos_x < count_x);
      ins_more  = (ptr_x > pos_x);
      del_more  = (CMPW'(ptr_inc) < count_x);
      scan_more = (ptr_ff < count_ff);
      rev_more  = (lo_inc < hi_dec);
   end

   // shared compare unit
   cmp_flags_type                flags;
   logic signed [DATA_WIDTH-1:0] cmp_upper;

   assign cmp_upper = (state_ff == S_SRCH) ? val_ff : res_big_ff;

   ale_cmp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cmp (
      .sample (rd_data_ff),
      .upper  (cmp_upper),
      .lower  (res_small_ff),
      .flags  (flags)
   );

   // store port control
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = rd_data_ff;
      mem_re = 1'b0;
      mem_ra = '0;
      unique case (state_ff)
         S_START: begin
            unique case (act_ff)
               ACT_APPEND: begin
                  mem_we = !full;
                  mem_wa = count_ff[AW-1:0];
                  mem_wd = val_ff;
               end
               ACT_GET: begin
                  mem_re = pos_ok;
                  mem_ra = pos_a;
               end
               ACT_SET: begin
                  mem_we = pos_ok;
                  mem_wa = pos_a;
                  mem_wd = val_ff;
               end
               ACT_REVERSE: begin
                  mem_re = (count_ff > CW'(1));
               end
               default: ;
            endcase
         end
         S_INS: begin
            mem_we = pend_ff;
            mem_wa = wa_ff;
            mem_re = ins_more;
            mem_ra = ptr_dec[AW-1:0];
         end
         S_PUT: begin
            mem_we = 1'b1;
            mem_wa = pos_a;
            mem_wd = val_ff;
         end
         S_DEL: begin
            mem_we = pend_ff;
            mem_wa = wa_ff;
            mem_re = del_more;
            mem_ra = ptr_inc[AW-1:0];
         end
         S_SRCH, S_MM: begin
            mem_re = scan_more;
            mem_ra = ptr_ff[AW-1:0];
         end
         S_RHI: begin
            mem_re = 1'b1;
            mem_ra = wa_ff;
         end
         S_WLO: begin
            mem_we = 1'b1;
            mem_wa = ptr_ff[AW-1:0];
            mem_re = 1'b1;           // prefetch next low entry
            mem_ra = lo_inc;
         end
         S_WHI: begin
            mem_we = 1'b1;
            mem_wa = wa_ff;
            mem_wd = tmp_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  act_ff   <= action_type'(req_action);
                  pos_ff   <= req_position;
                  val_ff   <= DATA_WIDTH'(req_operand_value);
                  state_ff <= S_START;
               end
            end
            S_START: begin
               res_status_ff <= ST_OK;
               res_found_ff  <= '0;
               res_read_ff   <= '0;
               res_big_ff    <= '0;
               res_small_ff  <= '0;
               pend_ff       <= 1'b0;
               cmp_valid_ff  <= 1'b0;
               ptr_ff        <= '0;
               state_ff      <= S_POST;
               unique case (act_ff)
                  ACT_APPEND: begin
                     if (full) begin
                        res_status_ff <= ST_FULL;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  ACT_INSERT: begin
                     priority if (full) begin
                        res_status_ff <= ST_FULL;
                     end else if (ins_bad) begin
                        res_status_ff <= ST_RANGE;
                     end else begin
                        ptr_ff   <= count_ff;
                        state_ff <= S_INS;
                     end
                  end
                  ACT_DELETE: begin
                     if (!pos_ok) begin
                        res_status_ff <= ST_RANGE;
                     end else begin
                        ptr_ff   <= CW'(pos_ff);
                        state_ff <= S_DEL;
                     end
                  end
                  ACT_SEARCH: begin
                     if (count_ff == '0) begin
                        res_status_ff <= ST_NOT_FOUND;
                     end else begin
                        state_ff <= S_SRCH;
                     end
                  end
                  ACT_GET: begin
                     if (!pos_ok) begin
                        res_status_ff <= ST_RANGE;
                     end else begin
                        state_ff <= S_GET;
                     end
                  end
                  ACT_SET: begin
                     if (!pos_ok) begin
                        res_status_ff <= ST_RANGE;
                     end
                  end
                  ACT_MAXMIN: begin
                     if (count_ff == '0) begin
                        res_status_ff <= ST_EMPTY;
                     end else begin
                        state_ff <= S_MM;
                     end
                  end
                  ACT_REVERSE: begin
                     if (count_ff > CW'(1)) begin
                        wa_ff    <= AW'(count_ff - 1'b1);
                        state_ff <= S_RHI;
                     end
                  end
                  default: ;
               endcase
            end
            S_INS: begin
               // move entry ptr-1 up to ptr, top down
               pend_ff <= ins_more;
               if (ins_more) begin
                  wa_ff  <= ptr_ff[AW-1:0];
                  ptr_ff <= ptr_dec;
               end else begin
                  state_ff <= S_PUT;
               end
            end
            S_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_POST;
            end
            S_DEL: begin
               // move entry ptr+1 down to ptr, bottom up
               pend_ff <= del_more;
               if (del_more) begin
                  wa_ff  <= ptr_ff[AW-1:0];
                  ptr_ff <= ptr_inc;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_POST;
               end
            end
            S_SRCH: begin
               priority if (cmp_valid_ff && flags.match) begin
                  res_found_ff <= cmp_idx_ff;
                  state_ff     <= S_POST;
               end else if (scan_more) begin
                  cmp_valid_ff <= 1'b1;
                  cmp_idx_ff   <= ptr_ff[AW-1:0];
                  ptr_ff       <= ptr_inc;
               end else begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_POST;
               end
            end
            S_GET: begin
               res_read_ff <= rd_data_ff;
               state_ff    <= S_POST;
            end
            S_MM: begin
               if (cmp_valid_ff) begin
                  if (cmp_idx_ff == '0) begin
                     res_big_ff   <= rd_data_ff;
                     res_small_ff <= rd_data_ff;
                  end else begin
                     if (flags.above) begin
                        res_big_ff <= rd_data_ff;
                     end
                     if (flags.below) begin
                        res_small_ff <= rd_data_ff;
                     end
                  end
               end
               if (scan_more) begin
                  cmp_valid_ff <= 1'b1;
                  cmp_idx_ff   <= ptr_ff[AW-1:0];
                  ptr_ff       <= ptr_inc;
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_RHI: begin
               tmp_ff   <= rd_data_ff;   // low entry
               state_ff <= S_WLO;
            end
            S_WLO: begin
               state_ff <= S_WHI;
            end
            S_WHI: begin
               ptr_ff   <= ptr_inc;
               wa_ff    <= hi_dec;
               state_ff <= rev_more ? S_RHI : S_POST;
            end
            S_POST: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_found_ff  <= 6'(res_found_ff);
                  rsp_read_ff   <= 32'($unsigned(res_read_ff));
                  rsp_big_ff    <= 32'($unsigned(res_big_ff));
                  rsp_small_ff  <= 32'($unsigned(res_small_ff));
                  rsp_count_ff  <= 7'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE) && !reset;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_largest        = rsp_big_ff;
   assign rsp_smallest       = rsp_small_ff;
   assign rsp_entry_count    = rsp_count_ff;

   logic at_rest;
   assign at_rest = (state_ff == S_IDLE) || (state_ff == S_POST);

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == S_START)
   `ASSERT_NEXT(a_count_hold, clock, reset, at_rest, count_ff == $past(count_ff))
   `ASSERT_IMPLY(a_write_busy, clock, reset, mem_we, !at_rest)

endmodule

FILE: rtl/ale_cmp.sv
// ----------------------------------------------------------------------------
// ale_cmp
// Shared signed compare unit: equality and order against two references.
// ----------------------------------------------------------------------------
module ale_cmp
   import ale_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic signed [DATA_WIDTH-1:0] sample,
   input  logic signed [DATA_WIDTH-1:0] upper,
   input  logic signed [DATA_WIDTH-1:0] lower,
   output cmp_flags_type                flags
);

   always_comb begin
      flags.match = (sample == upper);
      flags.above = (sample > upper);
      flags.below = (sample < lower);
   end

endmodule
